// File: rtl/gdcm_pkg.sv
// Shared types and constants of the grid cost map block.
// Holds the beat payloads, the heap key, the cost entry, the micro-op codes
// and the status bundle. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gdcm_pkg;

    localparam int CNT_W = 12;

    // Command codes of an input beat.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Step costs in Q8.8: one straight step and one diagonal step.
    localparam logic [16:0] STEP_STRAIGHT = 17'd256;
    localparam logic [16:0] STEP_DIAGONAL = 17'd362;

    // Neighbor directions 0..7, one bit per direction.
    localparam logic [7:0] DX_NEG = 8'b0000_0111;
    localparam logic [7:0] DX_POS = 8'b1110_0000;
    localparam logic [7:0] DY_NEG = 8'b0010_1001;
    localparam logic [7:0] DY_POS = 8'b1001_0100;
    localparam logic [7:0] DIR_DIAG = 8'b1010_0101;

    // Micro-op codes that the controller hands to the datapath.
    localparam int OP_W = 5;
    typedef logic [OP_W-1:0] gdcm_op_t;
    localparam gdcm_op_t OP_NOP      = 5'd0;
    localparam gdcm_op_t OP_CLR_ALL  = 5'd1;
    localparam gdcm_op_t OP_ACCEPT   = 5'd2;
    localparam gdcm_op_t OP_LOAD     = 5'd3;
    localparam gdcm_op_t OP_QREAD    = 5'd4;
    localparam gdcm_op_t OP_CLR_COST = 5'd5;
    localparam gdcm_op_t OP_START    = 5'd6;
    localparam gdcm_op_t OP_PUSH     = 5'd7;
    localparam gdcm_op_t OP_PUSH_UP  = 5'd8;
    localparam gdcm_op_t OP_PUSH_CMP = 5'd9;
    localparam gdcm_op_t OP_POP_CHK  = 5'd10;
    localparam gdcm_op_t OP_POP_TOP  = 5'd11;
    localparam gdcm_op_t OP_SIFT     = 5'd12;
    localparam gdcm_op_t OP_SIFT_CMP = 5'd13;
    localparam gdcm_op_t OP_EXPAND   = 5'd14;
    localparam gdcm_op_t OP_STALE    = 5'd15;
    localparam gdcm_op_t OP_DIR      = 5'd16;
    localparam gdcm_op_t OP_RELAX    = 5'd17;
    localparam gdcm_op_t OP_DIR_NEXT = 5'd18;
    localparam gdcm_op_t OP_EMIT     = 5'd19;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  cell_x;
        logic [4:0]  cell_y;
        logic [1:0]  cell_layer;
        logic        blocked;
        logic        occupied;
        logic [15:0] max_range;
    } gdcm_in_t;

    typedef struct packed {
        logic             reached;
        logic [15:0]      cost;
        logic [4:0]       parent_x;
        logic [4:0]       parent_y;
        logic [1:0]       parent_layer;
        logic             queue_overflow;
        logic [CNT_W-1:0] cells_reached;
    } gdcm_out_t;

    // Heap key; its bit order gives the (cost, x, y, layer) ordering.
    typedef struct packed {
        logic [15:0] cost;
        logic [4:0]  x;
        logic [4:0]  y;
        logic [1:0]  z;
    } gdcm_key_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] cost;
        logic [4:0]  px;
        logic [4:0]  py;
        logic [1:0]  pz;
    } gdcm_cost_t;

    typedef struct packed {
        logic sweep_last;
        logic in_range;
        logic heap_full;
        logic heap_empty;
        logic hole_zero;
        logic up_le;
        logic sift_leaf;
        logic sift_stop;
        logic stale;
        logic nbr_ok;
        logic relax_skip;
        logic dir_last;
        logic out_free;
    } gdcm_status_t;

endpackage

`default_nettype wire

// File: rtl/grid_dijkstra_cost_map.sv
// Top level of the grid cost map block: range-limited shortest-path costs on
// an 8-connected grid. Instantiates gdcm_ctrl and gdcm_datapath; uses gdcm_pkg.
//
// Usage. Input beats on s_valid/s_ready/s_data carry one command each: load
// writes one cell's blocked and occupied bits, search clears all costs and
// runs Dijkstra from the addressed cell within its layer, and query reads one
// cell's cost and parent. Every command returns exactly one beat on
// m_valid/m_ready/m_data. The queue_overflow field always shows whether the
// most recent search had to drop a heap entry.
//
// Sequencing. One command is worked on at a time. A load or a query goes
// through its write or read state and then the emit state, which registers
// the result beat, and the next command is accepted once the block is back
// in idle. A search first walks the whole cost memory once, one cell per
// cycle, then for every popped heap entry runs the sift-down loop, the stale
// check and a read and relax step for each neighbor, with a walk up the heap
// each time a neighbor is pushed. Each memory has a single write port.
//
// Reset. After aresetn is released the block runs a clearing pass over the
// cell map and cost memory, one cell per cycle, with s_ready low. When the
// receiver stalls, the result stays in the output register; the next command
// is still accepted and worked on, and its result waits until the output
// register frees up.
`timescale 1ns / 1ps
`default_nettype none

module grid_dijkstra_cost_map #(
    parameter int GRID_W      = 32,
    parameter int GRID_H      = 32,
    parameter int NUM_LAYERS  = 3,
    parameter int QUEUE_DEPTH = 4096
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire gdcm_pkg::gdcm_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output gdcm_pkg::gdcm_out_t      m_data
);
    import gdcm_pkg::*;

    gdcm_op_t     op;
    gdcm_status_t status;

    // The controller owns sequencing; the datapath owns every memory and
    // register that holds data, and reports the comparisons it needs.
    gdcm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_data.command),
        .status    (status),
        .s_ready   (s_ready),
        .op        (op)
    );

    gdcm_datapath #(
        .GRID_W      (GRID_W),
        .GRID_H      (GRID_H),
        .NUM_LAYERS  (NUM_LAYERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .status  (status)
    );

endmodule

`default_nettype wire

// File: rtl/gdcm_ctrl.sv
// Sequencer of the grid cost map block.
// Walks commands, clearing passes, heap operations and neighbor relaxation.
// Depends on gdcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdcm_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic [1:0]            s_command,
    input  wire gdcm_pkg::gdcm_status_t status,
    output logic                       s_ready,
    output gdcm_pkg::gdcm_op_t         op
);
    import gdcm_pkg::*;

    localparam logic [4:0] ST_RCLR     = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_LOAD     = 5'd2;
    localparam logic [4:0] ST_QRD      = 5'd3;
    localparam logic [4:0] ST_SCLR     = 5'd4;
    localparam logic [4:0] ST_START    = 5'd5;
    localparam logic [4:0] ST_PUSH     = 5'd6;
    localparam logic [4:0] ST_PUSH_UP  = 5'd7;
    localparam logic [4:0] ST_PUSH_CMP = 5'd8;
    localparam logic [4:0] ST_POP_CHK  = 5'd9;
    localparam logic [4:0] ST_POP_TOP  = 5'd10;
    localparam logic [4:0] ST_SIFT     = 5'd11;
    localparam logic [4:0] ST_SIFT_CMP = 5'd12;
    localparam logic [4:0] ST_EXPAND   = 5'd13;
    localparam logic [4:0] ST_STALE    = 5'd14;
    localparam logic [4:0] ST_DIR      = 5'd15;
    localparam logic [4:0] ST_RELAX    = 5'd16;
    localparam logic [4:0] ST_DIR_NEXT = 5'd17;
    localparam logic [4:0] ST_EMIT     = 5'd18;

    logic [4:0] state_reg, state_next;
    logic       ret_nbr_reg, ret_nbr_next;
    logic [4:0] push_ret;

    assign s_ready  = (state_reg == ST_IDLE);
    assign push_ret = ret_nbr_reg ? ST_DIR_NEXT : ST_POP_CHK;

    always_comb begin
        state_next   = state_reg;
        ret_nbr_next = ret_nbr_reg;
        op           = OP_NOP;
        unique case (state_reg)
            ST_RCLR: begin
                op = OP_CLR_ALL;
                if (status.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op = OP_ACCEPT;
                    case (s_command)
                        CMD_LOAD:   state_next = ST_LOAD;
                        CMD_SEARCH: state_next = ST_SCLR;
                        CMD_QUERY:  state_next = ST_QRD;
                        default:    state_next = ST_EMIT;
                    endcase
                end
            end
            ST_LOAD: begin
                op         = OP_LOAD;
                state_next = ST_EMIT;
            end
            ST_QRD: begin
                op         = OP_QREAD;
                state_next = ST_EMIT;
            end
            ST_SCLR: begin
                op = OP_CLR_COST;
                if (status.sweep_last) state_next = status.in_range ? ST_START : ST_EMIT;
            end
            ST_START: begin
                op           = OP_START;
                ret_nbr_next = 1'b0;
                state_next   = ST_PUSH;
            end
            ST_PUSH: begin
                op         = OP_PUSH;
                state_next = status.heap_full ? push_ret : ST_PUSH_UP;
            end
            ST_PUSH_UP: begin
                op         = OP_PUSH_UP;
                state_next = status.hole_zero ? push_ret : ST_PUSH_CMP;
            end
            ST_PUSH_CMP: begin
                op         = OP_PUSH_CMP;
                state_next = status.up_le ? push_ret : ST_PUSH_UP;
            end
            ST_POP_CHK: begin
                op         = OP_POP_CHK;
                state_next = status.heap_empty ? ST_EMIT : ST_POP_TOP;
            end
            ST_POP_TOP: begin
                op         = OP_POP_TOP;
                state_next = status.heap_empty ? ST_EXPAND : ST_SIFT;
            end
            ST_SIFT: begin
                op         = OP_SIFT;
                state_next = status.sift_leaf ? ST_EXPAND : ST_SIFT_CMP;
            end
            ST_SIFT_CMP: begin
                op         = OP_SIFT_CMP;
                state_next = status.sift_stop ? ST_EXPAND : ST_SIFT;
            end
            ST_EXPAND: begin
                op         = OP_EXPAND;
                state_next = ST_STALE;
            end
            ST_STALE: begin
                op         = OP_STALE;
                state_next = status.stale ? ST_POP_CHK : ST_DIR;
            end
            ST_DIR: begin
                op         = OP_DIR;
                state_next = status.nbr_ok ? ST_RELAX : ST_DIR_NEXT;
            end
            ST_RELAX: begin
                op = OP_RELAX;
                if (status.relax_skip) begin
                    state_next = ST_DIR_NEXT;
                end else begin
                    ret_nbr_next = 1'b1;
                    state_next   = ST_PUSH;
                end
            end
            ST_DIR_NEXT: begin
                op         = OP_DIR_NEXT;
                state_next = status.dir_last ? ST_POP_CHK : ST_DIR;
            end
            ST_EMIT: begin
                op = OP_EMIT;
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_RCLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RCLR;
            ret_nbr_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_nbr_reg <= ret_nbr_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gdcm_datapath.sv
// Datapath of the grid cost map block: cell map, cost map and heap memories,
// the heap pointers, neighbor arithmetic and the output register.
// Depends on gdcm_pkg; driven by micro-ops from gdcm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module gdcm_datapath #(
    parameter int GRID_W      = 32,
    parameter int GRID_H      = 32,
    parameter int NUM_LAYERS  = 3,
    parameter int QUEUE_DEPTH = 4096
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire gdcm_pkg::gdcm_op_t     op,
    input  wire gdcm_pkg::gdcm_in_t     s_data,
    input  wire logic                   m_ready,
    output logic                        m_valid,
    output gdcm_pkg::gdcm_out_t         m_data,
    output gdcm_pkg::gdcm_status_t      status
);
    import gdcm_pkg::*;

    localparam int XB    = $clog2(GRID_W);
    localparam int YB    = $clog2(GRID_H);
    localparam int LB    = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int CELLS = NUM_LAYERS * (1 << (XB + YB));
    localparam int CW    = $clog2(CELLS);
    localparam int QW    = $clog2(QUEUE_DEPTH);

    logic [1:0] map_mem  [CELLS];
    gdcm_cost_t cost_mem [CELLS];
    gdcm_key_t  heap_mem [QUEUE_DEPTH];

    gdcm_in_t         in_reg;
    logic [QW:0]      count_reg;
    logic [QW-1:0]    hole_reg;
    gdcm_key_t        key_reg, top_reg, last_reg, rd_a_reg, rd_b_reg;
    gdcm_cost_t       cost_rd_reg;
    logic [1:0]       map_rd_reg;
    logic [2:0]       dir_reg;
    logic [CW-1:0]    sweep_reg;
    logic [CNT_W-1:0] reached_reg;
    logic             ovf_reg;
    logic             m_valid_reg;
    gdcm_out_t        m_data_reg;

    // Cells are addressed as {layer, row, column}.
    function automatic logic [CW-1:0] cidx(input logic [4:0] x, input logic [4:0] y,
                                           input logic [1:0] z);
        cidx = CW'({LB'(z), YB'(y), XB'(x)});
    endfunction

    logic          in_range, out_free, sweep_last;
    logic [CW-1:0] in_idx, top_idx, nbr_idx;
    logic          x_neg, x_pos, y_neg, y_pos, x_ok, y_ok;
    logic [5:0]    nx_wide, ny_wide;
    logic [16:0]   new_cost;
    logic          relax_skip;
    logic [QW-1:0] hole_m1, up_idx;
    logic [QW:0]   child_l, cnt_m1;
    logic [QW+1:0] child_r;
    logic          sift_leaf, has_r, pick_r;
    gdcm_key_t     pick_key;
    logic [QW-1:0] pick_idx;

    assign in_range = (32'(in_reg.cell_x) < GRID_W) && (32'(in_reg.cell_y) < GRID_H)
                   && (32'(in_reg.cell_layer) < NUM_LAYERS);
    assign in_idx     = cidx(in_reg.cell_x, in_reg.cell_y, in_reg.cell_layer);
    assign top_idx    = cidx(top_reg.x, top_reg.y, top_reg.z);
    assign out_free   = !m_valid_reg || m_ready;
    assign sweep_last = (sweep_reg == CW'(CELLS - 1));

    // Neighbor in direction dir_reg of the cell being expanded.
    assign x_neg   = DX_NEG[dir_reg];
    assign x_pos   = DX_POS[dir_reg];
    assign y_neg   = DY_NEG[dir_reg];
    assign y_pos   = DY_POS[dir_reg];
    assign nx_wide = {1'b0, top_reg.x} + {5'd0, x_pos} - {5'd0, x_neg};
    assign ny_wide = {1'b0, top_reg.y} + {5'd0, y_pos} - {5'd0, y_neg};
    assign x_ok    = !(x_neg && top_reg.x == 5'd0) && (32'(nx_wide) < GRID_W);
    assign y_ok    = !(y_neg && top_reg.y == 5'd0) && (32'(ny_wide) < GRID_H);
    assign nbr_idx = cidx(nx_wide[4:0], ny_wide[4:0], top_reg.z);
    assign new_cost = {1'b0, top_reg.cost} + (DIR_DIAG[dir_reg] ? STEP_DIAGONAL : STEP_STRAIGHT);
    assign relax_skip = map_rd_reg[1] || map_rd_reg[0]
                     || (new_cost > {1'b0, in_reg.max_range})
                     || (cost_rd_reg.valid && new_cost[15:0] >= cost_rd_reg.cost);

    // Heap index arithmetic.
    assign hole_m1   = hole_reg - QW'(1);
    assign up_idx    = hole_m1 >> 1;
    assign child_l   = {hole_reg, 1'b1};
    assign child_r   = {1'b0, child_l} + (QW + 2)'(1);
    assign cnt_m1    = count_reg - (QW + 1)'(1);
    assign sift_leaf = (child_l >= count_reg);
    assign has_r     = (child_r < {1'b0, count_reg});
    assign pick_r    = has_r && (rd_b_reg < rd_a_reg);
    assign pick_key  = pick_r ? rd_b_reg : rd_a_reg;
    assign pick_idx  = pick_r ? child_r[QW-1:0] : child_l[QW-1:0];

    always_comb begin
        status.sweep_last = sweep_last;
        status.in_range   = in_range;
        status.heap_full  = (count_reg == (QW + 1)'(QUEUE_DEPTH));
        status.heap_empty = (count_reg == '0);
        status.hole_zero  = (hole_reg == '0);
        status.up_le      = (rd_a_reg <= key_reg);
        status.sift_leaf  = sift_leaf;
        status.sift_stop  = (last_reg <= pick_key);
        status.stale      = (top_reg.cost > cost_rd_reg.cost);
        status.nbr_ok     = x_ok && y_ok;
        status.relax_skip = relax_skip;
        status.dir_last   = (dir_reg == 3'd7);
        status.out_free   = out_free;
    end

    // Memory port control.
    logic          map_we, map_re, cost_we, cost_re, heap_we, heap_re;
    logic [CW-1:0] map_waddr, cost_waddr, cost_raddr;
    logic [1:0]    map_wdata;
    gdcm_cost_t    cost_wdata;
    logic [QW-1:0] heap_waddr, heap_ra, heap_rb;
    gdcm_key_t     heap_wdata;

    always_comb begin
        map_we     = 1'b0;
        map_re     = 1'b0;
        map_waddr  = sweep_reg;
        map_wdata  = 2'b00;
        cost_we    = 1'b0;
        cost_re    = 1'b0;
        cost_waddr = sweep_reg;
        cost_wdata = '0;
        cost_raddr = in_idx;
        heap_we    = 1'b0;
        heap_re    = 1'b0;
        heap_waddr = hole_reg;
        heap_wdata = key_reg;
        heap_ra    = '0;
        heap_rb    = cnt_m1[QW-1:0];
        unique case (op)
            OP_CLR_ALL: begin
                map_we  = 1'b1;
                cost_we = 1'b1;
            end
            OP_CLR_COST: cost_we = 1'b1;
            OP_LOAD: begin
                map_we    = in_range;
                map_waddr = in_idx;
                map_wdata = {in_reg.blocked, in_reg.occupied};
            end
            OP_QREAD: cost_re = 1'b1;
            OP_START: begin
                cost_we    = 1'b1;
                cost_waddr = in_idx;
                cost_wdata = '{valid: 1'b1, cost: 16'd0, px: in_reg.cell_x,
                               py: in_reg.cell_y, pz: in_reg.cell_layer};
            end
            OP_PUSH_UP: begin
                heap_we = status.hole_zero;
                heap_re = 1'b1;
                heap_ra = up_idx;
            end
            OP_PUSH_CMP: begin
                heap_we    = 1'b1;
                heap_wdata = status.up_le ? key_reg : rd_a_reg;
            end
            OP_POP_CHK: heap_re = 1'b1;
            OP_SIFT: begin
                heap_we    = sift_leaf;
                heap_wdata = last_reg;
                heap_re    = 1'b1;
                heap_ra    = child_l[QW-1:0];
                heap_rb    = child_r[QW-1:0];
            end
            OP_SIFT_CMP: begin
                heap_we    = 1'b1;
                heap_wdata = status.sift_stop ? last_reg : pick_key;
            end
            OP_EXPAND: begin
                cost_re    = 1'b1;
                cost_raddr = top_idx;
            end
            OP_DIR: begin
                map_re     = 1'b1;
                cost_re    = 1'b1;
                cost_raddr = nbr_idx;
            end
            OP_RELAX: begin
                cost_we    = !relax_skip;
                cost_waddr = nbr_idx;
                cost_wdata = '{valid: 1'b1, cost: new_cost[15:0], px: top_reg.x,
                               py: top_reg.y, pz: top_reg.z};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (map_we) map_mem[map_waddr] <= map_wdata;
        if (map_re) map_rd_reg <= map_mem[nbr_idx];
    end

    always_ff @(posedge aclk) begin
        if (cost_we) cost_mem[cost_waddr] <= cost_wdata;
        if (cost_re) cost_rd_reg <= cost_mem[cost_raddr];
    end

    always_ff @(posedge aclk) begin
        if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
        if (heap_re) begin
            rd_a_reg <= heap_mem[heap_ra];
            rd_b_reg <= heap_mem[heap_rb];
        end
    end

    // Result beat.
    gdcm_out_t result;
    logic      is_search, q_hit;

    assign is_search = (in_reg.command == CMD_SEARCH);
    assign q_hit     = (in_reg.command == CMD_QUERY) && in_range && cost_rd_reg.valid;

    always_comb begin
        result                = '0;
        result.reached        = is_search || q_hit;
        result.queue_overflow = ovf_reg;
        if (q_hit) begin
            result.cost         = cost_rd_reg.cost;
            result.parent_x     = cost_rd_reg.px;
            result.parent_y     = cost_rd_reg.py;
            result.parent_layer = cost_rd_reg.pz;
        end
        if (is_search) result.cells_reached = reached_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (op == OP_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= result;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (op)
                OP_CLR_ALL, OP_CLR_COST: sweep_reg <= sweep_last ? '0 : sweep_reg + CW'(1);
                OP_ACCEPT: begin
                    in_reg <= s_data;
                    if (s_data.command == CMD_SEARCH) begin
                        ovf_reg     <= 1'b0;
                        count_reg   <= '0;
                        reached_reg <= '0;
                    end
                end
                OP_START: begin
                    reached_reg <= CNT_W'(1);
                    key_reg     <= '{cost: 16'd0, x: in_reg.cell_x, y: in_reg.cell_y,
                                     z: in_reg.cell_layer};
                end
                OP_PUSH: begin
                    if (status.heap_full) begin
                        ovf_reg <= 1'b1;
                    end else begin
                        hole_reg  <= count_reg[QW-1:0];
                        count_reg <= count_reg + (QW + 1)'(1);
                    end
                end
                OP_PUSH_CMP: if (!status.up_le) hole_reg <= up_idx;
                OP_POP_CHK:  if (!status.heap_empty) count_reg <= cnt_m1;
                OP_POP_TOP: begin
                    top_reg  <= rd_a_reg;
                    last_reg <= rd_b_reg;
                    hole_reg <= '0;
                end
                OP_SIFT_CMP: if (!status.sift_stop) hole_reg <= pick_idx;
                OP_STALE:    dir_reg <= 3'd0;
                OP_RELAX: begin
                    if (!relax_skip) begin
                        if (!cost_rd_reg.valid) reached_reg <= reached_reg + CNT_W'(1);
                        key_reg <= '{cost: new_cost[15:0], x: nx_wide[4:0], y: ny_wide[4:0],
                                     z: top_reg.z};
                    end
                end
                OP_DIR_NEXT: dir_reg <= dir_reg + 3'd1;
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: rtl/gdcm_checker.sv
// Port-level checks for the grid cost map block, bound to its top level.
// Depends on gdcm_pkg and grid_dijkstra_cost_map.
`timescale 1ns / 1ps
`default_nettype none

module gdcm_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire gdcm_pkg::gdcm_in_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire gdcm_pkg::gdcm_out_t m_data
);
    import gdcm_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // Commands are taken one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second command taken while one is in work");

    // A result with cells reached is marked reached and carries no cost.
    a_search_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.cells_reached != '0 |-> m_data.reached && m_data.cost == '0)
        else $error("search result carries query fields");

    // An unreached answer carries no cost or parent.
    a_unreached_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.reached |-> m_data.cost == '0 && m_data.parent_x == '0
            && m_data.parent_y == '0 && m_data.parent_layer == '0)
        else $error("unreached answer carries cost or parent");

endmodule

bind grid_dijkstra_cost_map gdcm_checker u_gdcm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// File: verif/tb_grid_dijkstra_cost_map.sv
// Self-checking testbench of grid_dijkstra_cost_map: a behavioral cost map
// predicts each result beat, which is compared with what the block returns.
// Depends on gdcm_pkg and the grid_dijkstra_cost_map RTL only.
`timescale 1ns / 1ps

module tb_grid_dijkstra_cost_map;
    import gdcm_pkg::*;

    localparam int GW = 32;
    localparam int GH = 32;
    localparam int GL = 3;
    localparam int CELLS = GW * GH * GL;
    localparam int HEAP_DEPTH = 4096;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int LONG_HOLD = 600;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    gdcm_in_t s_data;
    logic m_valid;
    logic m_ready;
    gdcm_out_t m_data;

    grid_dijkstra_cost_map i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Predicted state of the cost map. The heap mirrors the block's ordering
    // exactly, since ties between equal costs decide which parent a cell keeps.
    bit              map_blocked [CELLS];
    bit              map_occupied[CELLS];
    bit              cost_known  [CELLS];
    logic [15:0]     cost_val    [CELLS];
    logic [11:0]     parent_of   [CELLS];
    longint unsigned heap_keys   [HEAP_DEPTH];
    int              heap_size;
    bit              heap_dropped;

    gdcm_out_t expected_beats[$];
    int  mismatches;
    bit  idle_enable;
    bit  hold_request;
    int  last_x;
    int  last_y;
    int  last_z;

    // Clock with a 12 ns period.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int cell_at(int x, int y, int z);
        return (z * GH + y) * GW + x;
    endfunction

    function automatic void heap_insert(longint unsigned key);
        int i;
        int up;
        if (heap_size >= HEAP_DEPTH) begin
            heap_dropped = 1'b1;
            return;
        end
        i = heap_size;
        heap_size++;
        while (i > 0) begin
            up = (i - 1) / 2;
            if (heap_keys[up] <= key) break;
            heap_keys[i] = heap_keys[up];
            i = up;
        end
        heap_keys[i] = key;
    endfunction

    function automatic longint unsigned heap_take();
        longint unsigned top;
        longint unsigned last;
        int i;
        int c;
        top = heap_keys[0];
        i = 0;
        heap_size--;
        if (heap_size == 0) return top;
        last = heap_keys[heap_size];
        forever begin
            c = 2 * i + 1;
            if (c >= heap_size) break;
            if (c + 1 < heap_size && heap_keys[c + 1] < heap_keys[c]) c++;
            if (last <= heap_keys[c]) break;
            heap_keys[i] = heap_keys[c];
            i = c;
        end
        heap_keys[i] = last;
        return top;
    endfunction

    // Range-limited Dijkstra within the start cell's layer; returns the
    // number of cells that got a cost.
    function automatic int flood_costs(int sx, int sy, int sz, int limit);
        int reached_n;
        int cc, cx, cy, cz, nx, ny, n, nc, d;
        int dx[8];
        int dy[8];
        longint unsigned k;
        dx = '{-1, -1, -1, 0, 0, 1, 1, 1};
        dy = '{-1, 0, 1, -1, 1, -1, 0, 1};
        foreach (cost_known[i]) begin
            cost_known[i] = 1'b0;
            cost_val[i] = '0;
        end
        heap_size = 0;
        heap_dropped = 1'b0;
        if (sx >= GW || sy >= GH || sz >= GL) return 0;
        n = cell_at(sx, sy, sz);
        cost_known[n] = 1'b1;
        cost_val[n] = '0;
        parent_of[n] = {sx[4:0], sy[4:0], sz[1:0]};
        reached_n = 1;
        heap_insert({40'd0, sx[7:0], sy[7:0], sz[7:0]});
        while (heap_size > 0) begin
            k = heap_take();
            cc = int'((k >> 24) & 64'hFFFF);
            cx = int'((k >> 16) & 64'hFF);
            cy = int'((k >> 8) & 64'hFF);
            cz = int'(k & 64'hFF);
            if (cc > cost_val[cell_at(cx, cy, cz)]) continue;
            for (d = 0; d < 8; d++) begin
                nx = cx + dx[d];
                ny = cy + dy[d];
                if (nx < 0 || nx >= GW || ny < 0 || ny >= GH) continue;
                n = cell_at(nx, ny, cz);
                if (map_blocked[n] || map_occupied[n]) continue;
                // Diagonal steps are the ones that move on both axes.
                nc = cc + ((dx[d] != 0 && dy[d] != 0) ? 362 : 256);
                if (nc > limit) continue;
                if (!cost_known[n] || nc < cost_val[n]) begin
                    if (!cost_known[n]) reached_n++;
                    cost_val[n] = nc[15:0];
                    cost_known[n] = 1'b1;
                    parent_of[n] = {cx[4:0], cy[4:0], cz[1:0]};
                    heap_insert((longint'(nc) << 24) | (longint'(nx) << 16) |
                                (longint'(ny) << 8) | longint'(cz));
                end
            end
        end
        return reached_n;
    endfunction

    function automatic gdcm_out_t predict_answer(gdcm_in_t c);
        gdcm_out_t r;
        bit in_grid;
        int i;
        int cnt;
        r = '0;
        in_grid = c.cell_layer < GL;
        i = cell_at(c.cell_x, c.cell_y, c.cell_layer);
        case (c.command)
            CMD_LOAD: begin
                if (in_grid) begin
                    map_blocked[i] = c.blocked;
                    map_occupied[i] = c.occupied;
                end
            end
            CMD_SEARCH: begin
                cnt = flood_costs(c.cell_x, c.cell_y, c.cell_layer, c.max_range);
                r.reached = 1'b1;
                r.cells_reached = cnt[CNT_W-1:0];
            end
            CMD_QUERY: begin
                if (in_grid && cost_known[i]) begin
                    r.reached = 1'b1;
                    r.cost = cost_val[i];
                    {r.parent_x, r.parent_y, r.parent_layer} = parent_of[i];
                end
            end
            default: ;
        endcase
        r.queue_overflow = heap_dropped;
        return r;
    endfunction

    // Receiver: random stall bursts, one long hold-off on request, and none
    // once idling is switched off.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result checker: every beat must match the oldest prediction.
    always @(posedge aclk) begin
        gdcm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", m_data);
            end else begin
                want = expected_beats.pop_front();
                if (m_data.reached !== want.reached || m_data.cost !== want.cost ||
                    m_data.parent_x !== want.parent_x ||
                    m_data.parent_y !== want.parent_y ||
                    m_data.parent_layer !== want.parent_layer ||
                    m_data.queue_overflow !== want.queue_overflow ||
                    m_data.cells_reached !== want.cells_reached) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, m_data);
                end
            end
        end
    end

    // Offers one beat and returns once it is accepted; valid stays high so a
    // following beat can go out back to back.
    task automatic send_cmd(input gdcm_in_t c);
        gdcm_out_t predicted;
        @(negedge aclk);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= c;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_answer(c);
        expected_beats.insert(expected_beats.size(), predicted);
    endtask

    // Stops offering beats and waits for every outstanding result.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic gdcm_in_t make_cmd(logic [1:0] op, int x, int y, int z,
                                          bit b, bit o, int range_q88);
        gdcm_in_t c;
        c.command = op;
        c.cell_x = x[4:0];
        c.cell_y = y[4:0];
        c.cell_layer = z[1:0];
        c.blocked = b;
        c.occupied = o;
        c.max_range = range_q88[15:0];
        return c;
    endfunction

    // Corners, the full range, a blocked start cell, out-of-range layer and
    // the unused command code.
    task automatic test_directed();
        send_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_LOAD, 1, 1, 0, 1, 0, 0));
        send_cmd(make_cmd(CMD_LOAD, 1, 0, 0, 0, 1, 0));
        send_cmd(make_cmd(CMD_LOAD, 31, 31, 2, 1, 1, 0));
        send_cmd(make_cmd(CMD_LOAD, 5, 5, 3, 1, 1, 0));
        send_cmd(make_cmd(CMD_SEARCH, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_QUERY, 0, 1, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_SEARCH, 0, 0, 0, 0, 0, 65535));
        send_cmd(make_cmd(CMD_QUERY, 31, 31, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_QUERY, 2, 2, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_QUERY, 1, 1, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_SEARCH, 31, 31, 2, 0, 0, 362));
        send_cmd(make_cmd(CMD_QUERY, 30, 30, 2, 0, 0, 0));
        send_cmd(make_cmd(CMD_QUERY, 30, 31, 2, 0, 0, 0));
        send_cmd(make_cmd(CMD_QUERY, 31, 31, 3, 0, 0, 0));
        send_cmd(make_cmd(CMD_SEARCH, 4, 4, 3, 0, 0, 65535));
        send_cmd(make_cmd(CMD_QUERY, 4, 4, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_UNUSED, 31, 31, 3, 1, 1, 65535));
        send_cmd(make_cmd(CMD_SEARCH, 10, 20, 1, 0, 0, 255));
        send_cmd(make_cmd(CMD_QUERY, 10, 20, 1, 0, 0, 0));
        drain_results();
    endtask

    // The receiver holds off long enough for the block to stop taking beats.
    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (30) send_cmd(make_cmd(CMD_QUERY, $urandom_range(0, 31),
                                      $urandom_range(0, 31), 1, 0, 0, 0));
        drain_results();
    endtask

    task automatic random_cmd();
        int pick;
        int z;
        int rng;
        pick = $urandom_range(0, 99);
        z = ($urandom_range(0, 40) == 0) ? 3 : $urandom_range(0, 2);
        if (pick < 5) begin
            rng = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 2048);
            last_x = $urandom_range(0, 31);
            last_y = $urandom_range(0, 31);
            last_z = z;
            send_cmd(make_cmd(CMD_SEARCH, last_x, last_y, z, $urandom_range(0, 1),
                              $urandom_range(0, 1), rng));
        end else if (pick < 35) begin
            send_cmd(make_cmd(CMD_LOAD, $urandom_range(0, 31), $urandom_range(0, 31), z,
                              $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0,
                              $urandom_range(0, 65535)));
        end else if (pick < 98) begin
            // Most queries land near the last search start so they hit costs.
            send_cmd(make_cmd(CMD_QUERY, (last_x + $urandom_range(0, 12) + 26) % 32,
                              (last_y + $urandom_range(0, 12) + 26) % 32,
                              ($urandom_range(0, 7) == 0) ? z : last_z,
                              $urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 65535)));
        end else begin
            send_cmd(make_cmd(CMD_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                              z, $urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 65535)));
        end
    endtask

    // Random traffic; a pause for all results midway, no idling at the end.
    task automatic test_random();
        repeat (600) random_cmd();
        drain_results();
        repeat (500) random_cmd();
        idle_enable = 1'b0;
        repeat (150) random_cmd();
        drain_results();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        mismatches = 0;
        idle_enable = 1'b1;
        hold_request = 1'b0;
        last_x = 0;
        last_y = 0;
        last_z = 0;
        foreach (map_blocked[i]) begin
            map_blocked[i] = 1'b0;
            map_occupied[i] = 1'b0;
            cost_known[i] = 1'b0;
            cost_val[i] = '0;
            parent_of[i] = '0;
        end
        heap_size = 0;
        heap_dropped = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_backpressure();
        test_random();

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
